// ===== hw/rtl/mlap_pkg.sv =====
`timescale 1ns / 1ps

package mlap_pkg;

    localparam int MAX_VOXELS_DEF  = 32768;
    localparam int SAMPLE_BITS_DEF = 32;

    localparam int DIM_W   = 8;
    localparam int INV_W   = 32;
    localparam int ADDR_W  = 15;
    localparam int IN_SW   = 32;
    localparam int LAP_W   = 40;
    localparam int CODE_W  = 6;
    localparam int CFG_IW  = 2;
    localparam int PLANE_W = 2 * DIM_W;
    localparam int GRID_W  = 3 * DIM_W;

    localparam logic [DIM_W-1:0] DIM_RST = DIM_W'(32);
    localparam logic [INV_W-1:0] INV_RST = INV_W'(65536);
    localparam logic [DIM_W-1:0] DIM_MIN = DIM_W'(4);

    localparam logic signed [LAP_W-1:0] LAP_MAX = {1'b0, {(LAP_W-1){1'b1}}};
    localparam logic signed [LAP_W-1:0] LAP_MIN = {1'b1, {(LAP_W-1){1'b0}}};

    localparam logic [1:0] CODE_NONE = 2'd0;
    localparam logic [1:0] CODE_BCK  = 2'd1;
    localparam logic [1:0] CODE_FWD  = 2'd2;
    localparam logic [1:0] CODE_CEN  = 2'd3;

    localparam logic REQ_STORE   = 1'b0;
    localparam logic REQ_COMPUTE = 1'b1;

    localparam logic ST_OK  = 1'b0;
    localparam logic ST_BAD = 1'b1;

    typedef enum logic [CFG_IW-1:0] {
        REG_DIM_X  = 2'd0,
        REG_DIM_Y  = 2'd1,
        REG_DIM_Z  = 2'd2,
        REG_INV_H2 = 2'd3
    } t_cfg_idx;

    typedef enum logic [4:0] {
        S_IDLE, S_PL, S_GR, S_CHK, S_DIVZ, S_DIVY, S_RDC, S_CEN,
        S_AXIS, S_MK1, S_MK2, S_TRM, S_TRD, S_TUSE, S_ABS, S_MLO,
        S_MHI, S_SAT, S_DONE
    } t_state;

    typedef struct packed {
        logic                    req_type;
        logic [ADDR_W-1:0]       voxel_addr;
        logic signed [IN_SW-1:0] sample;
        logic                    in_mask;
    } t_req;

    typedef struct packed {
        logic signed [LAP_W-1:0] lap_value;
        logic [CODE_W-1:0]       stencil_code;
        logic                    status;
    } t_rsp;

endpackage

// ===== hw/rtl/mlap_ram.sv =====
`timescale 1ns / 1ps

module mlap_ram #(
    parameter int WIDTH = 33,
    parameter int DEPTH = 32768
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/masked_laplacian_3d_stencil_top.sv =====
`timescale 1ns / 1ps

// Masked 3D Laplacian over a voxel grid held in one on-chip memory of MAX_VOXELS
// entries (sample plus mask bit). A store request gives no response. A compute
// request keeps the block busy from acceptance until it is ready again, including
// any wait of its response for the receiver: two 16-step restoring divisions
// recover the coordinates, then the centre, up to six mask bits and up to nine
// neighbour samples are read one at a time through the single read port of the
// memory, and the scaled sum is formed with one shared 32x32 multiplier over two
// passes. A refused request ends after the grid checks, an unmasked one after the
// centre read. One request is in flight at a time; memory is undefined until written.
module masked_laplacian_3d_stencil_top #(
    parameter int MAX_VOXELS  = mlap_pkg::MAX_VOXELS_DEF,
    parameter int SAMPLE_BITS = mlap_pkg::SAMPLE_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  mlap_pkg::t_req                  i_in,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output mlap_pkg::t_rsp                  o_out,
    input  logic                            i_cfg_we,
    input  logic [mlap_pkg::CFG_IW-1:0]     i_cfg_idx,
    input  logic [mlap_pkg::INV_W-1:0]      i_cfg_data
);

    import mlap_pkg::*;

    localparam int AW    = $clog2(MAX_VOXELS);
    localparam int ACC_W = SAMPLE_BITS + 7;
    localparam int RW    = SAMPLE_BITS + 1;
    localparam int EW    = 25;

    t_state r_state, n_state;

    logic [DIM_W-1:0]   r_dx, r_dy, r_dz;
    logic [INV_W-1:0]   r_inv;
    t_req               r_req;
    logic [PLANE_W-1:0] r_plane;
    logic [GRID_W-1:0]  r_grid;
    logic [16:0]        r_rem;
    logic [15:0]        r_quo;
    logic [3:0]         r_bit;
    logic [DIM_W-1:0]   r_cx, r_cy, r_cz;
    logic [1:0]         r_axis, r_code, r_k;
    logic [CODE_W-1:0]  r_codes;
    logic               r_mplus;
    logic signed [SAMPLE_BITS-1:0] r_x0;
    logic signed [ACC_W-1:0]       r_acc;
    logic [63:0]        r_mag, r_plo, r_phi;
    logic               r_neg;
    t_rsp               r_res, r_out;
    logic               r_out_valid;

    logic [31:0] mul_a, mul_b;
    logic [63:0] mul_p;
    logic [15:0] div_d;
    logic [16:0] t_rem, n_rem;
    logic [15:0] n_quo;
    logic        div_ge;
    logic [DIM_W-1:0]   ax_c, ax_dim;
    logic [PLANE_W-1:0] ax_st;
    logic [1:0]         rd_mag;
    logic               rd_fwd;
    logic [17:0]        off;
    logic [EW-1:0]      a_ext, a_off;
    logic               in_rng, central, last_k;
    logic               ram_we;
    logic [AW-1:0]      ram_raddr;
    logic [RW-1:0]      ram_wdata, ram_rdata;
    logic signed [SAMPLE_BITS-1:0] rd_s;
    logic signed [ACC_W-1:0]       s_ext, x0_ext, term;
    logic [ACC_W-1:0]   mag_c;
    logic [49:0]        q;
    logic               q_sat;
    logic signed [LAP_W-1:0] lap;
    logic               addr_ok, grid_bad;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dx  <= DIM_RST;
            r_dy  <= DIM_RST;
            r_dz  <= DIM_RST;
            r_inv <= INV_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                REG_DIM_X:  r_dx  <= i_cfg_data[DIM_W-1:0];
                REG_DIM_Y:  r_dy  <= i_cfg_data[DIM_W-1:0];
                REG_DIM_Z:  r_dz  <= i_cfg_data[DIM_W-1:0];
                REG_INV_H2: r_inv <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (r_state)
            S_PL:    begin mul_a = 32'(r_dx);           mul_b = 32'(r_dy);  end
            S_GR:    begin mul_a = 32'(r_plane);        mul_b = 32'(r_dz);  end
            S_MLO:   begin mul_a = r_mag[31:0];          mul_b = r_inv;      end
            default: begin mul_a = r_mag[63:32];         mul_b = r_inv;      end
        endcase
        mul_p = 64'(mul_a) * 64'(mul_b);
    end

    always_comb begin
        div_d  = (r_state == S_DIVZ) ? r_plane : 16'(r_dx);
        t_rem  = {r_rem[15:0], r_quo[15]};
        div_ge = t_rem >= {1'b0, div_d};
        n_rem  = div_ge ? t_rem - {1'b0, div_d} : t_rem;
        n_quo  = {r_quo[14:0], div_ge};
    end

    always_comb begin
        case (r_axis)
            2'd0:    begin ax_c = r_cx; ax_dim = r_dx; ax_st = PLANE_W'(1);    end
            2'd1:    begin ax_c = r_cy; ax_dim = r_dy; ax_st = PLANE_W'(r_dx); end
            default: begin ax_c = r_cz; ax_dim = r_dz; ax_st = r_plane;        end
        endcase
        central = (r_code == CODE_CEN);
        last_k  = central ? (r_k == 2'd1) : (r_k == 2'd2);
        case (r_state)
            S_AXIS:  begin rd_mag = 2'd1; rd_fwd = 1'b1; end
            S_MK1:   begin rd_mag = 2'd1; rd_fwd = 1'b0; end
            default: begin
                rd_mag = central ? 2'd1 : r_k + 2'd1;
                rd_fwd = central ? (r_k == 2'd1) : (r_code == CODE_FWD);
            end
        endcase
        case (rd_mag)
            2'd1:    off = 18'(ax_st);
            2'd2:    off = 18'(ax_st) << 1;
            default: off = 18'(ax_st) + (18'(ax_st) << 1);
        endcase
        a_ext = EW'(r_req.voxel_addr);
        a_off = rd_fwd ? a_ext + EW'(off) : a_ext - EW'(off);
        in_rng = rd_fwd ? ((9'(ax_c) + 9'(rd_mag)) < 9'(ax_dim))
                        : (ax_c >= DIM_W'(rd_mag));
        ram_raddr = (r_state == S_RDC) ? AW'(r_req.voxel_addr) : AW'(a_off);
    end

    always_comb begin
        addr_ok  = (32'(r_req.voxel_addr) < 32'(r_grid)) &&
                   (32'(r_req.voxel_addr) < 32'(MAX_VOXELS));
        grid_bad = (r_dx < DIM_MIN) || (r_dy < DIM_MIN) || (r_dz < DIM_MIN) ||
                   (32'(r_grid) > 32'(MAX_VOXELS));
        ram_we    = (r_state == S_CHK) && (r_req.req_type == REQ_STORE) && addr_ok;
        ram_wdata = {r_req.in_mask, SAMPLE_BITS'(r_req.sample)};
    end

    mlap_ram #(
        .WIDTH (RW),
        .DEPTH (MAX_VOXELS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (AW'(r_req.voxel_addr)),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        rd_s   = ram_rdata[SAMPLE_BITS-1:0];
        s_ext  = ACC_W'(rd_s);
        x0_ext = ACC_W'(r_x0);
        if (central) begin
            term = s_ext;
        end else begin
            case (r_k)
                2'd0:    term = -((s_ext <<< 2) + s_ext);
                2'd1:    term = s_ext <<< 2;
                default: term = -s_ext;
            endcase
        end
        mag_c = r_acc[ACC_W-1] ? ACC_W'(-r_acc) : ACC_W'(r_acc);
        q_sat = (r_phi[63:24] != 40'd0);
        q = (50'(r_phi[23:0]) << 16) + 50'(r_plo[63:16]) + 50'(r_plo[15]);
        if (r_neg) begin
            lap = (q_sat || q >= 50'(LAP_MAX) + 50'd1) ? LAP_MIN : -LAP_W'(q);
        end else begin
            lap = (q_sat || q > 50'(LAP_MAX)) ? LAP_MAX : LAP_W'(q);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (i_in_valid) n_state = S_PL;
            S_PL:   n_state = S_GR;
            S_GR:   n_state = S_CHK;
            S_CHK: begin
                if (r_req.req_type == REQ_STORE) n_state = S_IDLE;
                else if (grid_bad || !addr_ok) n_state = S_DONE;
                else n_state = S_DIVZ;
            end
            S_DIVZ: if (r_bit == 4'd15) n_state = S_DIVY;
            S_DIVY: if (r_bit == 4'd15) n_state = S_RDC;
            S_RDC:  n_state = S_CEN;
            S_CEN:  n_state = ram_rdata[RW-1] ? S_AXIS : S_DONE;
            S_AXIS: begin
                if (ax_c == '0 || ax_c == ax_dim - DIM_W'(1)) n_state = S_TRM;
                else n_state = S_MK1;
            end
            S_MK1:  n_state = S_MK2;
            S_MK2:  n_state = S_TRM;
            S_TRM: begin
                if (r_code != CODE_NONE) n_state = S_TRD;
                else if (r_axis == 2'd2) n_state = S_ABS;
                else n_state = S_AXIS;
            end
            S_TRD: begin
                if (in_rng) n_state = S_TUSE;
                else if (!last_k) n_state = S_TRD;
                else if (r_axis == 2'd2) n_state = S_ABS;
                else n_state = S_AXIS;
            end
            S_TUSE: begin
                if (!last_k) n_state = S_TRD;
                else if (r_axis == 2'd2) n_state = S_ABS;
                else n_state = S_AXIS;
            end
            S_ABS:  n_state = S_MLO;
            S_MLO:  n_state = S_MHI;
            S_MHI:  n_state = S_SAT;
            S_SAT:  n_state = S_DONE;
            S_DONE: if (!r_out_valid || i_out_ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: r_req <= i_in;
            S_PL:   r_plane <= mul_p[PLANE_W-1:0];
            S_GR:   r_grid  <= mul_p[GRID_W-1:0];
            S_CHK: begin
                r_res <= '{lap_value: '0, stencil_code: '0, status: ST_BAD};
                r_quo <= 16'(r_req.voxel_addr);
                r_rem <= '0;
                r_bit <= '0;
            end
            S_DIVZ: begin
                r_bit <= r_bit + 4'd1;
                if (r_bit == 4'd15) begin
                    r_cz  <= n_quo[DIM_W-1:0];
                    r_quo <= n_rem[15:0];
                    r_rem <= '0;
                end else begin
                    r_quo <= n_quo;
                    r_rem <= n_rem;
                end
            end
            S_DIVY: begin
                r_bit <= r_bit + 4'd1;
                r_quo <= n_quo;
                r_rem <= n_rem;
                if (r_bit == 4'd15) begin
                    r_cy <= n_quo[DIM_W-1:0];
                    r_cx <= n_rem[DIM_W-1:0];
                end
            end
            S_CEN: begin
                r_res   <= '{lap_value: '0, stencil_code: '0, status: ST_OK};
                r_x0    <= rd_s;
                r_acc   <= '0;
                r_axis  <= '0;
                r_codes <= '0;
            end
            S_AXIS: begin
                if (ax_c == '0) r_code <= CODE_FWD;
                else if (ax_c == ax_dim - DIM_W'(1)) r_code <= CODE_BCK;
            end
            S_MK1: r_mplus <= ram_rdata[RW-1];
            S_MK2: r_code  <= {r_mplus, ram_rdata[RW-1]};
            S_TRM: begin
                r_codes[2*r_axis +: 2] <= r_code;
                r_k <= '0;
                if (r_code == CODE_CEN) r_acc <= r_acc - (x0_ext <<< 1);
                else if (r_code != CODE_NONE) r_acc <= r_acc + (x0_ext <<< 1);
                if (r_code == CODE_NONE) r_axis <= r_axis + 2'd1;
            end
            S_TRD: begin
                if (!in_rng) begin
                    r_k <= r_k + 2'd1;
                    if (last_k) r_axis <= r_axis + 2'd1;
                end
            end
            S_TUSE: begin
                r_acc <= r_acc + term;
                r_k   <= r_k + 2'd1;
                if (last_k) r_axis <= r_axis + 2'd1;
            end
            S_ABS: begin
                r_neg <= r_acc[ACC_W-1];
                r_mag <= 64'(mag_c);
            end
            S_MLO: r_plo <= mul_p;
            S_MHI: r_phi <= mul_p;
            S_SAT: r_res <= '{lap_value: lap, stencil_code: r_codes, status: ST_OK};
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_DONE && (!r_out_valid || i_out_ready)) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && (!r_out_valid || i_out_ready)) begin
            r_out <= r_res;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule
